>>> hw/rtl/lefr_pkg.sv
// ----------------------------------------------------------------------------
// LED effect frame renderer: shared package
// Entry layouts, effect and status codes, arithmetic constants and the
// function that builds the breathe (raised cosine) table.
// ----------------------------------------------------------------------------
package lefr_pkg;

  // Counter wide enough to hold the largest LED count of a frame (64).
  localparam int unsigned CNT_W = 7;

  // Effect codes.
  localparam logic [2:0] EFF_OFF     = 3'd0;
  localparam logic [2:0] EFF_SOLID   = 3'd1;
  localparam logic [2:0] EFF_BLINK   = 3'd2;
  localparam logic [2:0] EFF_DOUBLE  = 3'd3;
  localparam logic [2:0] EFF_BREATHE = 3'd4;

  // Write status codes.
  localparam logic [1:0] WS_OK         = 2'd0;
  localparam logic [1:0] WS_BAD_INDEX  = 2'd1;
  localparam logic [1:0] WS_BAD_EFFECT = 2'd2;
  localparam logic [1:0] WS_BAD_DUTY   = 2'd3;

  // Configuration register indexes (byte address bit 2).
  localparam logic REG_MASTER = 1'b0;
  localparam logic REG_ACTIVE = 1'b1;

  localparam logic [6:0]  DUTY_MAX  = 7'd100;
  localparam logic [16:0] Q16_ONE   = 17'h10000;

  // Double blink pulse: min(period / 6, 100).
  localparam logic [15:0] DBL_SPLIT   = 16'd600;
  localparam logic [6:0]  DBL_MAX     = 7'd100;
  localparam logic [13:0] SIXTH_RECIP = 14'd10923;

  // Channel divide by 255 * 100, done as a reciprocal multiply and one fix-up.
  localparam logic [23:0] CHAN_DIV   = 24'd25500;
  localparam logic [23:0] CHAN_RECIP = 24'd10779525;
  localparam int unsigned CHAN_SH    = 38;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } rgb_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  bright;
    logic [2:0]  effect;
    logic [15:0] period;
    logic [15:0] offset;
    logic [6:0]  duty;
  } led_entry_t;

  localparam led_entry_t ENTRY_RST = '{
    red: 8'd0, green: 8'd80, blue: 8'd255, bright: 8'd160,
    effect: EFF_BREATHE, period: 16'd1800, offset: 16'd0, duty: 7'd0
  };

  // Cosine of 2*pi*j/2^bits in Q30, first quadrant, by a Taylor series.
  function automatic longint cos_q30(input longint j, input int unsigned bits);
    logic [63:0] theta;
    logic [63:0] t2;
    logic [63:0] term;
    longint      sum;
    theta = (64'(j) * 64'd6746518852) >> bits;
    t2    = (theta * theta) >> 30;
    term  = 64'd1 << 30;
    sum   = longint'(64'd1 << 30);
    for (int n = 1; n <= 12; n++) begin
      term = ((term * t2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if ((n & 1) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(64'd1 << 30)) sum = longint'(64'd1 << 30);
    return sum;
  endfunction

  // Breathe table entry in Q16: (1 - cos) / 2, rounded and clamped.
  function automatic logic [16:0] breathe_q16(input longint k, input int unsigned bits);
    longint len;
    longint kk;
    longint c;
    longint b;
    len = longint'(1) << bits;
    kk  = (k <= (len >> 1)) ? k : len - k;
    c   = (kk <= (len >> 2)) ? cos_q30(kk, bits) : -cos_q30((len >> 1) - kk, bits);
    b   = ((longint'(1) <<< 30) - c + (longint'(1) <<< 14)) >>> 15;
    if (b < 0) b = 0;
    if (b > 65536) b = 65536;
    return 17'(b);
  endfunction

endpackage

>>> hw/rtl/led_effect_frame_renderer.sv
// ----------------------------------------------------------------------------
// LED effect frame renderer
// Per-LED effect table with blink, double blink and breathe rendering.
// A write result appears in the cycle after its transfer. A render steps through
// each active LED in turn (read, phase and scale, channel scaling, compare) and
// ends with a frame-end state; busy is high meanwhile.
// Results are strobes the receiver cannot stall. rst_n (synchronous) clears
// both tables to their reset entries and sets the first-frame flag.
// ----------------------------------------------------------------------------
module led_effect_frame_renderer import lefr_pkg::*; #(
  parameter int LED_SLOTS      = 64,
  parameter int SHORT_PULSE_MS = 50,
  parameter int COS_TABLE_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // Command channel
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [5:0]  in_led_index,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_brightness,
  input  logic [2:0]  in_effect,
  input  logic [15:0] in_period_ms,
  input  logic [15:0] in_phase_offset_ms,
  input  logic [6:0]  in_duty_percent,
  input  logic [31:0] in_now_ms,
  input  logic        in_force_refresh,
  // Result channel
  output logic        out_strobe,
  output logic [5:0]  out_index,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_last_in_frame,
  output logic [1:0]  out_write_status,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW      = (LED_SLOTS > 1) ? $clog2(LED_SLOTS) : 1;
  localparam int TAB_LEN = 1 << COS_TABLE_BITS;
  localparam int CAP     = (LED_SLOTS < 64) ? LED_SLOTS : 64;

  // One-hot sequencer states.
  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_RD   = 10'b00_0000_0010,
    ST_LD   = 10'b00_0000_0100,
    ST_MOD  = 10'b00_0000_1000,
    ST_IDX  = 10'b00_0001_0000,
    ST_SCL  = 10'b00_0010_0000,
    ST_CH   = 10'b00_0100_0000,
    ST_WAIT = 10'b00_1000_0000,
    ST_CMP  = 10'b01_0000_0000,
    ST_FIN  = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [6:0] master_r;
  logic [6:0] active_r;
  logic       cfg_we;
  logic [6:0] eff_n;

  // Frame control.
  logic [CNT_W-1:0] led_cnt_r;
  logic             first_r;
  logic             all_r;
  logic [31:0]      now_r;
  logic [16:0]      scale_r;
  logic [15:0]      phase_r;

  // Held result that waits to learn whether it is the last of the frame.
  logic       pend_vld_r;
  logic [5:0] pend_idx_r;
  rgb_t       pend_rgb_r;

  // Output registers.
  logic       out_strobe_r;
  logic [5:0] out_index_r;
  rgb_t       out_rgb_r;
  logic       out_last_r;
  logic [1:0] out_status_r;

  // Entry table and shown-colour table, each with one valid bit per entry.
  led_entry_t          set_mem [LED_SLOTS];
  rgb_t                shown_mem [LED_SLOTS];
  logic [LED_SLOTS-1:0] set_vld_r;
  logic [LED_SLOTS-1:0] shown_vld_r;
  led_entry_t          set_rd_r;
  rgb_t                shown_rd_r;
  logic                set_rv_r;
  logic                shown_rv_r;
  logic [IW-1:0]       rd_addr;
  logic [IW-1:0]       wr_addr;
  logic                rd_en;
  led_entry_t          ent;
  led_entry_t          new_entry;
  rgb_t                shown_cur;

  // Command decode.
  logic       accept;
  logic [1:0] wr_status;
  logic       wr_ok;

  // Divider and channel scaler.
  logic        div_start;
  logic [31:0] div_dividend;
  logic        div_done;
  logic [31:0] div_quo;
  logic [15:0] div_rem;
  logic        chan_done;
  rgb_t        chan_rgb;
  logic        emit;

  // Effect decisions.
  logic [23:0] blink_lhs;
  logic [23:0] blink_rhs;
  logic        blink_lit;
  logic [23:0] six_prod;
  logic [6:0]  dbl_p;
  logic [8:0]  dbl_p2;
  logic [8:0]  dbl_p3;
  logic        dbl_lit;

  logic [16:0] cos_rom [TAB_LEN];

  // The breathe table is fixed at elaboration.
  for (genvar k = 0; k < TAB_LEN; k++) begin : g_cos
    assign cos_rom[k] = breathe_q16(longint'(k), COS_TABLE_BITS);
  end

  // --------------------------------------------------------------------------
  // Configuration port. Writes land when the access phase completes; reads
  // are returned combinationally since pready never drops.
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_ACTIVE) ? {25'd0, active_r} : {25'd0, master_r};

  // The effective LED count never exceeds the table or the 6-bit output index.
  assign eff_n = (active_r > 7'(CAP)) ? 7'(CAP) : active_r;

  // --------------------------------------------------------------------------
  // Command decode. Writes are checked in the order index, effect, duty and
  // are answered from the idle state without ever raising busy.
  // --------------------------------------------------------------------------
  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    if ({1'b0, in_led_index} >= eff_n) begin
      wr_status = WS_BAD_INDEX;
    end else if (in_effect > EFF_BREATHE) begin
      wr_status = WS_BAD_EFFECT;
    end else if (in_duty_percent > DUTY_MAX) begin
      wr_status = WS_BAD_DUTY;
    end else begin
      wr_status = WS_OK;
    end
  end

  assign wr_ok   = accept && !in_action && (wr_status == WS_OK);
  assign wr_addr = IW'(in_led_index);
  assign rd_addr = IW'(led_cnt_r);
  assign rd_en   = (state_r == ST_RD);

  assign new_entry = '{
    red: in_red, green: in_green, blue: in_blue, bright: in_brightness,
    effect: in_effect, period: in_period_ms, offset: in_phase_offset_ms,
    duty: in_duty_percent
  };

  // --------------------------------------------------------------------------
  // Tables. Both are read once per LED in the read state and the registered
  // data stays put until the next LED, so the sequencer needs no forwarding:
  // the shown colour is written back in the compare state, well after its read.
  // An entry never written reads as its reset value through its valid bit.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (wr_ok) set_mem[wr_addr] <= new_entry;
    if (rd_en) begin
      set_rd_r   <= set_mem[rd_addr];
      shown_rd_r <= shown_mem[rd_addr];
      set_rv_r   <= set_vld_r[rd_addr];
      shown_rv_r <= shown_vld_r[rd_addr];
    end
    if (state_r == ST_CMP && emit) shown_mem[rd_addr] <= chan_rgb;
  end

  assign ent       = set_rv_r ? set_rd_r : ENTRY_RST;
  assign shown_cur = shown_rv_r ? shown_rd_r : '0;

  // --------------------------------------------------------------------------
  // Divider: first the phase (time plus offset, modulo the period), then for
  // breathe the table index (phase scaled up, divided by the period).
  // --------------------------------------------------------------------------
  assign div_dividend = (state_r == ST_LD) ? now_r + 32'(ent.offset)
                                           : 32'(div_rem) << COS_TABLE_BITS;
  assign div_start = ((state_r == ST_LD) && (state_nxt == ST_MOD)) ||
                     ((state_r == ST_MOD) && div_done && (ent.effect == EFF_BREATHE));

  lefr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (ent.period),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // --------------------------------------------------------------------------
  // Blink: with a duty, lit while phase < floor(period * duty / 100), which is
  // the same as 100 * (phase + 1) <= period * duty. Without a duty the pulse
  // is the short fixed one, cut to the period.
  // Double blink: pulse p = min(period / 6, 100), lit in [0, p) and [2p, 3p).
  // Below a period of 600 the sixth comes from a reciprocal multiply that is
  // exact over that range.
  // --------------------------------------------------------------------------
  always_comb begin
    blink_lhs = 24'(17'(phase_r) + 17'd1) * 24'(DUTY_MAX);
    blink_rhs = 24'(ent.period) * 24'(ent.duty);
    if (ent.duty != '0) begin
      blink_lit = blink_lhs <= blink_rhs;
    end else begin
      blink_lit = (phase_r < ent.period) && (32'(phase_r) < 32'(SHORT_PULSE_MS));
    end
    six_prod = 24'(ent.period[9:0]) * 24'(SIXTH_RECIP);
    dbl_p    = (ent.period < DBL_SPLIT) ? six_prod[22:16] : DBL_MAX;
    dbl_p2   = {1'b0, dbl_p, 1'b0};
    dbl_p3   = dbl_p2 + 9'(dbl_p);
    dbl_lit  = (phase_r < 16'(dbl_p)) ||
               ((phase_r >= 16'(dbl_p2)) && (phase_r < 16'(dbl_p3)));
  end

  lefr_chan u_chan (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (state_r == ST_CH),
    .colour ('{red: ent.red, green: ent.green, blue: ent.blue}),
    .bright (ent.bright),
    .scale  (scale_r),
    .master (master_r),
    .done   (chan_done),
    .result (chan_rgb)
  );

  assign emit = all_r || (chan_rgb != shown_cur);

  // --------------------------------------------------------------------------
  // Sequencer: read an entry, work out its scale, scale the channels, compare
  // with what was last shown, and move on to the next LED.
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_action) state_nxt = (eff_n == '0) ? ST_FIN : ST_RD;
      end
      ST_RD:   state_nxt = ST_LD;
      ST_LD: begin
        if (ent.effect == EFF_OFF || ent.effect == EFF_SOLID || ent.period == '0) begin
          state_nxt = ST_CH;
        end else begin
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        if (div_done) state_nxt = (ent.effect == EFF_BREATHE) ? ST_IDX : ST_SCL;
      end
      ST_IDX: begin
        if (div_done) state_nxt = ST_CH;
      end
      ST_SCL:  state_nxt = ST_CH;
      ST_CH:   state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (chan_done) state_nxt = ST_CMP;
      end
      ST_CMP: begin
        state_nxt = (CNT_W'(led_cnt_r + 1'b1) >= eff_n) ? ST_FIN : ST_RD;
      end
      ST_FIN:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      master_r     <= 7'd100;
      active_r     <= 7'd6;
      led_cnt_r    <= '0;
      first_r      <= 1'b1;
      all_r        <= 1'b0;
      pend_vld_r   <= 1'b0;
      out_strobe_r <= 1'b0;
      set_vld_r    <= '0;
      shown_vld_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (paddr[2] == REG_MASTER) begin
          master_r <= pwdata[6:0];
        end else begin
          active_r <= pwdata[6:0];
        end
      end
      if (wr_ok) set_vld_r[wr_addr] <= 1'b1;
      if (accept && in_action) begin
        led_cnt_r <= '0;
        all_r     <= first_r || in_force_refresh;
        first_r   <= 1'b0;
      end
      if (state_r == ST_CMP) begin
        led_cnt_r <= led_cnt_r + 1'b1;
        if (emit) begin
          pend_vld_r           <= 1'b1;
          shown_vld_r[rd_addr] <= 1'b1;
        end
      end
      if (state_r == ST_FIN) pend_vld_r <= 1'b0;
      out_strobe_r <= (accept && !in_action) ||
                      ((state_r == ST_CMP) && emit && pend_vld_r) ||
                      ((state_r == ST_FIN) && pend_vld_r);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept && in_action) now_r <= in_now_ms;
    if (state_r == ST_LD) scale_r <= (ent.effect == EFF_OFF) ? '0 : Q16_ONE;
    if (state_r == ST_MOD && div_done) phase_r <= div_rem;
    if (state_r == ST_IDX && div_done) scale_r <= cos_rom[div_quo[COS_TABLE_BITS-1:0]];
    if (state_r == ST_SCL) begin
      if (ent.effect == EFF_BLINK) begin
        scale_r <= blink_lit ? Q16_ONE : '0;
      end else begin
        scale_r <= dbl_lit ? Q16_ONE : '0;
      end
    end
    if (state_r == ST_CMP && emit) begin
      pend_idx_r <= led_cnt_r[5:0];
      pend_rgb_r <= chan_rgb;
    end
    // A held result goes out once the next one arrives, or at the frame end
    // where it is marked as the last.
    if (accept && !in_action) begin
      out_index_r  <= in_led_index;
      out_rgb_r    <= '0;
      out_last_r   <= 1'b0;
      out_status_r <= wr_status;
    end else if (state_r == ST_CMP && emit) begin
      out_index_r  <= pend_idx_r;
      out_rgb_r    <= pend_rgb_r;
      out_last_r   <= 1'b0;
      out_status_r <= WS_OK;
    end else if (state_r == ST_FIN) begin
      out_index_r  <= pend_idx_r;
      out_rgb_r    <= pend_rgb_r;
      out_last_r   <= 1'b1;
      out_status_r <= WS_OK;
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_index         = out_index_r;
  assign out_red           = out_rgb_r.red;
  assign out_green         = out_rgb_r.green;
  assign out_blue          = out_rgb_r.blue;
  assign out_last_in_frame = out_last_r;
  assign out_write_status  = out_status_r;

`ifndef SYNTHESIS
  // The last result of a frame leaves together with the return to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last_in_frame) |-> (state_r == ST_IDLE))
    else $error("last result without frame end");

  // The frame end always flushes the held result.
  a_fin_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |=> !pend_vld_r)
    else $error("held result survived frame end");

  // The phase lies below the period.
  a_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_MOD) && div_done) |-> (div_rem < ent.period))
    else $error("phase not below period");

  // Entries are only written between frames.
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wr_ok |-> (state_r == ST_IDLE))
    else $error("entry write during a frame");
`endif

endmodule

>>> hw/rtl/lefr_div.sv
// ----------------------------------------------------------------------------
// LED effect frame renderer: serial divider
// Restoring division of a 32-bit dividend by a non-zero 16-bit divisor,
// one quotient bit per cycle; done pulses once the last quotient bit is in.
// ----------------------------------------------------------------------------
module lefr_div import lefr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] quo,
  output logic [15:0] rem
);

  localparam logic [5:0] DIV_STEPS = 6'd32;

  logic [5:0]  cnt_r;
  logic        done_r;
  logic [31:0] quo_r;
  logic [15:0] rem_r;
  logic [15:0] div_r;
  logic [16:0] sh;
  logic        ge;
  logic [15:0] rem_nxt;

  always_comb begin
    sh      = {rem_r, quo_r[31]};
    ge      = sh >= {1'b0, div_r};
    rem_nxt = ge ? 16'(sh - {1'b0, div_r}) : sh[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= DIV_STEPS;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[30:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

>>> hw/rtl/lefr_chan.sv
// ----------------------------------------------------------------------------
// LED effect frame renderer: channel scaler
// Six-stage pipeline that scales red, green and blue by brightness, the
// Q16 effect scale and master brightness, divides and saturates at 255.
// ----------------------------------------------------------------------------
module lefr_chan import lefr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  rgb_t        colour,
  input  logic [7:0]  bright,
  input  logic [16:0] scale,
  input  logic [6:0]  master,
  output logic        done,
  output rgb_t        result
);

  logic [5:0]        vld_r;
  logic [2:0][7:0]   lane_in;
  logic [2:0][7:0]   ch_r;
  logic [7:0]        br_r;
  logic [16:0]       sc1_r, sc2_r, sc3_r;
  logic [6:0]        ms1_r, ms2_r;
  logic [2:0][15:0]  p1_r;
  logic [2:0][22:0]  t_r;
  logic [2:0][22:0]  w_r, w5_r;
  logic [2:0][8:0]   q0_r;
  logic [2:0][7:0]   res_r;
  logic [2:0][7:0]   res_nxt;
  logic [46:0]       recip_prod [3];
  logic [39:0]       sc_prod [3];
  logic [23:0]       back [3];
  logic [9:0]        qf [3];

  assign lane_in = {colour.red, colour.green, colour.blue};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sc_prod[c]    = 40'(t_r[c]) * 40'(sc3_r);
      recip_prod[c] = 47'(w_r[c]) * 47'(CHAN_RECIP);
      back[c]       = 24'(q0_r[c]) * CHAN_DIV;
      qf[c]         = 10'(q0_r[c]) + ((24'(w5_r[c]) - back[c] >= CHAN_DIV) ? 10'd1 : 10'd0);
      res_nxt[c]    = (qf[c] > 10'd255) ? 8'd255 : qf[c][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[4:0], start};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ch_r  <= lane_in;
      br_r  <= bright;
      sc1_r <= scale;
      ms1_r <= master;
    end
    sc2_r <= sc1_r;
    ms2_r <= ms1_r;
    sc3_r <= sc2_r;
    for (int c = 0; c < 3; c++) begin
      p1_r[c] <= 16'(ch_r[c]) * 16'(br_r);
      t_r[c]  <= 23'(23'(p1_r[c]) * 23'(ms2_r));
      w_r[c]  <= sc_prod[c][38:16];
      q0_r[c] <= recip_prod[c][CHAN_SH +: 9];
      w5_r[c] <= w_r[c];
    end
    if (vld_r[4]) res_r <= res_nxt;
  end

  assign done   = vld_r[5];
  assign result = '{red: res_r[2], green: res_r[1], blue: res_r[0]};

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED effect frame renderer testbench
// Drives entry writes and frame renders through the command port, changes
// master brightness and LED count over the APB port between phases, and
// checks every result strobe against an in-bench prediction of the frames.
// ----------------------------------------------------------------------------
module testbench;
  import lefr_pkg::*;

  // One command as presented on the input channel.
  typedef struct {
    logic        action;
    logic [5:0]  idx;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  bright;
    logic [2:0]  effect;
    logic [15:0] period;
    logic [15:0] offset;
    logic [6:0]  duty;
    logic [31:0] now;
    logic        force_all;
  } command_t;

  // One result strobe.
  typedef struct packed {
    logic [5:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
    logic [1:0] status;
  } pixel_t;

  localparam int ACTION_WRITE  = 0;
  localparam int ACTION_RENDER = 1;
  localparam int STALL_LIMIT   = 20000;

  // Keeps its own copy of the LED tables and predicts the pixels of each frame.
  class frame_predictor;
    led_entry_t  entries[64];
    rgb_t        shown[64];
    logic [16:0] cos_ramp[256];
    bit          first_render;
    int unsigned master;
    int unsigned count;
    pixel_t      pending_pixels[$];
    int          errors;
    int          reported;

    function new();
      longint unsigned theta, t2, term;
      longint          sum, c, b;
      int              kk, j;
      for (int i = 0; i < 64; i++) begin
        entries[i] = '{red: 0, green: 80, blue: 255, bright: 160, effect: EFF_BREATHE,
                       period: 1800, offset: 0, duty: 0};
        shown[i] = '0;
      end
      first_render = 1;
      master = 100;
      count = 6;
      // Raised cosine ramp in Q16, cosine by a Q30 Taylor series.
      for (int k = 0; k < 256; k++) begin
        kk = (k <= 128) ? k : 256 - k;
        j = (kk <= 64) ? kk : 128 - kk;
        theta = (longint'(j) * 64'd6746518852) / 256;
        t2 = (theta * theta) >> 30;
        term = 64'd1 << 30;
        sum = longint'(64'd1 << 30);
        for (int n = 1; n <= 12; n++) begin
          term = ((term * t2) >> 30) / longint'((2 * n - 1) * (2 * n));
          if (n % 2 == 1) sum -= longint'(term);
          else sum += longint'(term);
        end
        if (sum < 0) sum = 0;
        if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
        c = (kk <= 64) ? sum : -sum;
        b = ((longint'(1) << 30) - c + (longint'(1) << 14)) >>> 15;
        if (b < 0) b = 0;
        if (b > 65536) b = 65536;
        cos_ramp[k] = 17'(b);
      end
    endfunction

    function int unsigned leds_in_use();
      return (count > 64) ? 64 : count;
    endfunction

    function void set_register(logic index, int unsigned value);
      if (index == REG_MASTER) master = value & 'h7f;
      else count = value & 'h7f;
    endfunction

    function logic [16:0] scale_of(led_entry_t e, logic [31:0] now);
      logic [31:0] phase, pulse;
      logic [39:0] ramp_pos;
      if (e.effect == EFF_OFF) return 0;
      if (e.effect == EFF_SOLID || e.period == 0) return Q16_ONE;
      phase = (now + 32'(e.offset)) % 32'(e.period);
      if (e.effect == EFF_BLINK) begin
        if (e.duty > 0) pulse = 32'(e.period) * 32'(e.duty) / 100;
        else pulse = (e.period < 50) ? 32'(e.period) : 32'd50;
        return (phase < pulse) ? Q16_ONE : 17'd0;
      end
      if (e.effect == EFF_DOUBLE) begin
        pulse = (e.period / 6 < 100) ? 32'(e.period / 6) : 32'd100;
        return (phase < pulse || (phase >= 2 * pulse && phase < 3 * pulse)) ?
               Q16_ONE : 17'd0;
      end
      ramp_pos = {phase, 8'd0} / 40'(e.period);
      return cos_ramp[ramp_pos[7:0]];
    endfunction

    function logic [7:0] dim(logic [7:0] ch, logic [7:0] br, logic [16:0] sc);
      longint unsigned v;
      v = longint'(ch) * br * sc * master / (64'd25500 * 64'd65536);
      return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function void note_command(command_t cmd);
      pixel_t      p;
      logic [16:0] sc;
      rgb_t        col;
      int          first_pending;
      if (cmd.action == ACTION_WRITE) begin
        p = '{idx: cmd.idx, red: 0, green: 0, blue: 0, last: 0, status: WS_OK};
        if (cmd.idx >= leds_in_use()) p.status = WS_BAD_INDEX;
        else if (cmd.effect > EFF_BREATHE) p.status = WS_BAD_EFFECT;
        else if (cmd.duty > DUTY_MAX) p.status = WS_BAD_DUTY;
        else entries[cmd.idx] = '{red: cmd.red, green: cmd.green, blue: cmd.blue,
                                  bright: cmd.bright, effect: cmd.effect,
                                  period: cmd.period, offset: cmd.offset, duty: cmd.duty};
        pending_pixels.push_back(p);
        return;
      end
      first_pending = pending_pixels.size();
      for (int i = 0; i < leds_in_use(); i++) begin
        sc = scale_of(entries[i], cmd.now);
        col.red = dim(entries[i].red, entries[i].bright, sc);
        col.green = dim(entries[i].green, entries[i].bright, sc);
        col.blue = dim(entries[i].blue, entries[i].bright, sc);
        if (first_render || cmd.force_all || col != shown[i]) begin
          shown[i] = col;
          pending_pixels.push_back('{idx: 6'(i), red: col.red, green: col.green,
                                     blue: col.blue, last: 0, status: WS_OK});
        end
      end
      // The final pixel of the frame carries the last flag.
      if (pending_pixels.size() > first_pending)
        pending_pixels[pending_pixels.size() - 1].last = 1;
      first_render = 0;
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        errors++;
        if (reported++ < 10) $display("unexpected result: idx %0d rgb %0d %0d %0d",
                                      got.idx, got.red, got.green, got.blue);
        return;
      end
      want = pending_pixels.pop_front();
      if (got != want) begin
        errors++;
        if (reported++ < 10)
          $display("mismatch: expected idx %0d rgb %0d %0d %0d last %0d status %0d, got idx %0d rgb %0d %0d %0d last %0d status %0d",
                   want.idx, want.red, want.green, want.blue, want.last, want.status,
                   got.idx, got.red, got.green, got.blue, got.last, got.status);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic        in_action = 0;
  logic [5:0]  in_led_index = 0;
  logic [7:0]  in_red = 0, in_green = 0, in_blue = 0, in_brightness = 0;
  logic [2:0]  in_effect = 0;
  logic [15:0] in_period_ms = 0, in_phase_offset_ms = 0;
  logic [6:0]  in_duty_percent = 0;
  logic [31:0] in_now_ms = 0;
  logic        in_force_refresh = 0;
  logic        out_strobe;
  logic [5:0]  out_index;
  logic [7:0]  out_red, out_green, out_blue;
  logic        out_last_in_frame;
  logic [1:0]  out_write_status;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;

  frame_predictor pred = new();
  int          quiet_cycles = 0;
  bit          no_gaps = 0;
  logic [31:0] clock_ms = 0;

  always #5 clk = ~clk;

  led_effect_frame_renderer dut (.*);

  // Results cannot be held off, so every strobe is checked at the edge that ends it.
  always @(posedge clk) begin
    if (rst_n && out_strobe)
      pred.check_pixel('{idx: out_index, red: out_red, green: out_green, blue: out_blue,
                         last: out_last_in_frame, status: out_write_status});
  end

  // Watchdog: a long render with no changed LED stays silent until it ends,
  // so the limit sits well above the length of such a render.
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one command and hold it until the transfer completes.
  task automatic issue(command_t cmd);
    if (!no_gaps && $urandom_range(0, 99) < 6) begin
      start <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1;
    in_action <= cmd.action;
    in_led_index <= cmd.idx;
    in_red <= cmd.red;
    in_green <= cmd.green;
    in_blue <= cmd.blue;
    in_brightness <= cmd.bright;
    in_effect <= cmd.effect;
    in_period_ms <= cmd.period;
    in_phase_offset_ms <= cmd.offset;
    in_duty_percent <= cmd.duty;
    in_now_ms <= cmd.now;
    in_force_refresh <= cmd.force_all;
    do @(posedge clk); while (busy);
    pred.note_command(cmd);
  endtask

  // Let the block drain completely before touching a register.
  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (pred.pending_pixels.size() != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_register(logic index, int unsigned value);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    pred.set_register(index, value);
  endtask

  function automatic command_t entry_write(int idx, int effect, int duty, int period);
    command_t c;
    c = '{action: 1'(ACTION_WRITE), idx: 6'(idx), red: 8'($urandom), green: 8'($urandom),
          blue: 8'($urandom), bright: 8'($urandom), effect: 3'(effect),
          period: 16'(period), offset: 16'($urandom), duty: 7'(duty), now: $urandom,
          force_all: 1'($urandom)};
    return c;
  endfunction

  function automatic command_t frame_render(logic [31:0] now, bit force_all);
    command_t c;
    c = entry_write(0, 0, 0, 0);
    c.action = 1'(ACTION_RENDER);
    c.idx = 6'($urandom);
    c.now = now;
    c.force_all = force_all;
    return c;
  endfunction

  // Frame renders at moving times, else mostly valid writes to LEDs in use with lively timings, some rejects.
  function automatic command_t random_command();
    command_t    c;
    int unsigned n, sel;
    n = pred.leds_in_use();
    if ($urandom_range(0, 99) < 40) begin
      sel = $urandom_range(0, 3);
      if (sel == 0) clock_ms = $urandom;
      else clock_ms = clock_ms + $urandom_range(1, 400);
      return frame_render(clock_ms, $urandom_range(0, 99) < 20);
    end
    c = entry_write((n == 0 || $urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                    : $urandom_range(0, n - 1),
                    ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4),
                    0, 0);
    sel = $urandom_range(0, 9);
    c.duty = 7'((sel == 0) ? $urandom_range(101, 127) : (sel < 3) ? 0 : $urandom_range(1, 100));
    sel = $urandom_range(0, 9);
    c.period = 16'((sel == 0) ? 0 : (sel < 6) ? $urandom_range(1, 700) : $urandom);
    if ($urandom_range(0, 1)) c.offset = 16'($urandom_range(0, 1000));
    return c;
  endfunction

  initial begin
    int unsigned phase_master[6] = '{0, 127, 100, 0, 127, 55};
    int unsigned phase_count[6]  = '{64, 64, 2, 0, 127, 20};
    int unsigned phase_items[6]  = '{80, 80, 60, 15, 80, 75};
    command_t    c;

    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed part with the reset count of six LEDs.
    issue(frame_render(0, 0));                     // first frame emits all
    issue(frame_render(0, 0));                     // nothing changed
    issue(frame_render(32'hffff_ffff, 1));         // forced refresh, time wraps
    issue(entry_write(6, EFF_SOLID, 0, 10));       // index beyond count
    issue(entry_write(0, 7, 0, 10));               // bad effect
    issue(entry_write(0, EFF_BLINK, 101, 10));     // bad duty
    issue(entry_write(0, 5, 127, 10));             // effect checked before duty
    c = entry_write(0, EFF_SOLID, 100, 0);
    c.red = 255; c.green = 255; c.blue = 255; c.bright = 255;
    issue(c);
    c = entry_write(1, EFF_OFF, 0, 1000);
    issue(c);
    c = entry_write(2, EFF_BLINK, 0, 30);          // short pulse longer than period
    c.offset = 16'hffff;
    issue(c);
    issue(entry_write(3, EFF_BLINK, 0, 1000));     // fixed short pulse
    issue(entry_write(4, EFF_DOUBLE, 0, 1200));    // double blink capped pulse
    c = entry_write(5, EFF_BREATHE, 50, 0);        // zero period reads as solid
    c.red = 0; c.green = 0; c.blue = 0; c.bright = 0;
    issue(c);
    issue(frame_render(10, 0));
    issue(frame_render(120, 0));
    issue(frame_render(250, 1));
    issue(entry_write(5, EFF_BREATHE, 0, 400));
    issue(frame_render(100, 0));
    issue(frame_render(200, 0));
    issue(frame_render(300, 0));

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_register(REG_MASTER, phase_master[ph]);
      write_register(REG_ACTIVE, phase_count[ph]);
      no_gaps = (ph == 2);
      for (int k = 0; k < phase_items[ph]; k++) issue(random_command());
    end

    drain();
    if (pred.errors == 0 && pred.pending_pixels.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
